[design/asp_pkg.sv]
package asp_pkg;

  // Field widths of the streams and the configuration port.
  localparam int VALUE_BITS     = 24;
  localparam int SLOPE_BITS     = 32;
  localparam int DATA_BITS      = VALUE_BITS + SLOPE_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // Width of the wide intermediate results before saturation.
  localparam int WIDE_BITS = 44;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCHEME    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COURANT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_WIDTH = 3'd3;

  // Scheme codes.
  localparam logic [1:0] SCHEME_UPWIND     = 2'd0;
  localparam logic [1:0] SCHEME_FIVE_POINT = 2'd1;
  localparam logic [1:0] SCHEME_CIP        = 2'd2;

  typedef struct packed {
    logic [1:0]         scheme;
    logic signed [15:0] courant;
    logic [15:0]        cell_width;
    logic [23:0]        inv_width;
  } asp_cfg_t;

  // One cell update: values of cells i-2..i+2, slopes of cells i-1..i+1.
  typedef struct packed {
    logic [4:0][VALUE_BITS-1:0] fw;
    logic [2:0][SLOPE_BITS-1:0] gw;
    logic                       last;
  } asp_job_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_UP0, BK_UP1,
    BK_FP0, BK_FP1,
    BK_C0, BK_C1, BK_C2, BK_C3, BK_C4, BK_C5, BK_C6,
    BK_C7, BK_C8, BK_C9, BK_C10, BK_C11, BK_C12,
    BK_FIN
  } asp_state_t;

  // Load enables of the back end datapath.
  typedef struct packed {
    logic take;
    logic ld_prod;
    logic ld_acc;
    logic ld_t2;
    logic ld_t3;
    logic ld_a;
    logic ld_p;
    logic ld_dg;
    logic ld_df;
    logic ld_q;
    logic fin;
  } asp_ctl_t;

  // Add half an LSB, then shift right with floor.
  function automatic logic signed [59:0] rnd_shift(input logic signed [59:0] v,
                                                   input logic [4:0] n);
    logic signed [59:0] half;
    half = 60'sd1 <<< (n - 5'd1);
    return (v + half) >>> n;
  endfunction

  function automatic logic [VALUE_BITS-1:0] sat_value(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (VALUE_BITS - 1)) - WIDE_BITS'(1);
    lo = -hi - WIDE_BITS'(1);
    if (v > hi) return hi[VALUE_BITS-1:0];
    else if (v < lo) return lo[VALUE_BITS-1:0];
    else return v[VALUE_BITS-1:0];
  endfunction

  function automatic logic [SLOPE_BITS-1:0] sat_slope(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (SLOPE_BITS - 1)) - WIDE_BITS'(1);
    lo = -hi - WIDE_BITS'(1);
    if (v > hi) return hi[SLOPE_BITS-1:0];
    else if (v < lo) return lo[SLOPE_BITS-1:0];
    else return v[SLOPE_BITS-1:0];
  endfunction

endpackage

[design/asp_front.sv]
module asp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [asp_pkg::VALUE_BITS-1:0] in_value,
  input  logic [asp_pkg::SLOPE_BITS-1:0] in_slope,
  input  logic                in_last,
  output logic                job_valid,
  input  logic                job_ready,
  output asp_pkg::asp_job_t   job
);

  logic [4:0][asp_pkg::VALUE_BITS-1:0] vw_r, vw_nxt, vwn;
  logic [2:0][asp_pkg::SLOPE_BITS-1:0] sw_r, sw_nxt, swn;
  logic [1:0]        cs_r, cs_nxt;
  asp_pkg::asp_job_t jobs_r [3];
  asp_pkg::asp_job_t j1, j2, j3;
  logic [2:0]        pend_r, pend_nxt, pend_new;
  logic [1:0]        sel;
  logic              accept;

  assign in_ready = (pend_r == 3'b000);
  assign accept   = in_valid && in_ready;

  // Windows after the new cell shifts in.
  always_comb begin
    vwn = {vw_r[3:0], in_value};
    swn = {sw_r[1:0], in_slope};
  end

  // Build the updates that this cell releases.
  always_comb begin
    for (int k = 0; k < 5; k++) j1.fw[k] = vwn[4-k];
    j1.gw[0] = sw_r[2];
    j1.gw[1] = sw_r[1];
    j1.gw[2] = sw_r[0];
    j1.last  = 1'b0;

    for (int k = 0; k < 4; k++) j2.fw[k] = vwn[3-k];
    j2.fw[4] = '0;
    j2.gw[0] = swn[2];
    j2.gw[1] = swn[1];
    j2.gw[2] = swn[0];
    j2.last  = 1'b0;

    j3.fw[0] = vwn[2];
    j3.fw[1] = vwn[1];
    j3.fw[2] = vwn[0];
    j3.fw[3] = '0;
    j3.fw[4] = '0;
    j3.gw[0] = swn[1];
    j3.gw[1] = swn[0];
    j3.gw[2] = '0;
    j3.last  = 1'b1;

    pend_new[0] = (cs_r == 2'd2);
    pend_new[1] = in_last && (cs_r != 2'd0);
    pend_new[2] = in_last;
  end

  // Hand pending updates to the queue in order.
  always_comb begin
    if (pend_r[0]) sel = 2'd0;
    else if (pend_r[1]) sel = 2'd1;
    else sel = 2'd2;
    job_valid = |pend_r;
    job       = jobs_r[sel];
  end

  // Window and pending-mask next state.
  always_comb begin
    vw_nxt   = vw_r;
    sw_nxt   = sw_r;
    cs_nxt   = cs_r;
    pend_nxt = pend_r;
    if (job_valid && job_ready) begin
      pend_nxt[sel] = 1'b0;
    end
    if (accept) begin
      pend_nxt = pend_new;
      if (in_last) begin
        vw_nxt = '0;
        sw_nxt = '0;
        cs_nxt = 2'd0;
      end else begin
        vw_nxt = vwn;
        sw_nxt = swn;
        if (cs_r != 2'd2) cs_nxt = cs_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r   <= '0;
      sw_r   <= '0;
      cs_r   <= 2'd0;
      pend_r <= 3'b000;
    end else begin
      vw_r   <= vw_nxt;
      sw_r   <= sw_nxt;
      cs_r   <= cs_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Update snapshots, written only while nothing is pending.
  always_ff @(posedge clk) begin
    if (accept) begin
      jobs_r[0] <= j1;
      jobs_r[1] <= j2;
      jobs_r[2] <= j3;
    end
  end

endmodule

[design/asp_queue.sv]
module asp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  asp_pkg::asp_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output asp_pkg::asp_job_t pop_job
);

  asp_pkg::asp_job_t mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count.
  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

endmodule

[design/asp_back.sv]
module asp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  asp_pkg::asp_cfg_t cfg,
  input  logic              job_valid,
  output logic              job_ready,
  input  asp_pkg::asp_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [asp_pkg::VALUE_BITS-1:0] out_value,
  output logic [asp_pkg::SLOPE_BITS-1:0] out_slope,
  output logic              out_last
);

  localparam int W = asp_pkg::WIDE_BITS;

  asp_pkg::asp_state_t state_r, state_nxt;
  asp_pkg::asp_ctl_t   ctl;
  asp_pkg::asp_job_t   job_r;

  logic signed [58:0] prod_r, acc_r, mul;
  logic signed [33:0] opa;
  logic signed [24:0] opb;
  logic signed [17:0] t2_r, t3_r;
  logic signed [27:0] a_r;
  logic signed [33:0] p_r;
  logic signed [35:0] dg_r;
  logic signed [W-1:0] df_r;
  logic signed [26:0] q_r;
  logic out_valid_r;
  logic [asp_pkg::VALUE_BITS-1:0] out_value_r;
  logic [asp_pkg::SLOPE_BITS-1:0] out_slope_r;
  logic out_last_r;

  // Operands taken from the held update.
  logic signed [asp_pkg::VALUE_BITS-1:0] fm2, fm1, f, fp1, fp2, fu;
  logic signed [asp_pkg::SLOPE_BITS-1:0] g, gu;
  logic               s_pos;
  logic signed [17:0] t;
  logic signed [24:0] c25, t25, t2_25, t3_25, h25, inv25;
  logic signed [24:0] k1, k2, ka, kb, kc, kd;
  logic signed [25:0] dff;
  logic signed [26:0] up_a;
  logic signed [26:0] up_b;
  logic signed [29:0] fp_a, fp_b;
  logic signed [59:0] sum60, r15p, r15s, r16p, r16s, r17s, r10p;
  logic signed [W-1:0] x16, y10, nf, ng;
  logic               out_load;

  always_comb begin
    fm2 = job_r.fw[0];
    fm1 = job_r.fw[1];
    f   = job_r.fw[2];
    fp1 = job_r.fw[3];
    fp2 = job_r.fw[4];
    g   = job_r.gw[1];
    s_pos = (cfg.courant > 16'sd0);
    fu  = s_pos ? fm1 : fp1;
    gu  = s_pos ? $signed(job_r.gw[0]) : $signed(job_r.gw[2]);
    t   = cfg.courant[15] ? -18'(cfg.courant) : 18'(cfg.courant);

    c25   = 25'(cfg.courant);
    t25   = 25'(t);
    t2_25 = 25'(t2_r);
    t3_25 = 25'(t3_r);
    h25   = $signed({9'd0, cfg.cell_width});
    inv25 = $signed({1'b0, cfg.inv_width});

    // Polynomial weights of the cubic in the Courant magnitude.
    k1 = t3_25 - (t2_25 <<< 1) + t25;
    k2 = t3_25 - t2_25;
    ka = (t3_25 <<< 1) - (t2_25 <<< 1) - t2_25;
    kb = (t2_25 <<< 1) + t2_25 - (t25 <<< 2);
    kc = (t2_25 <<< 1) + t2_25 - (t25 <<< 1);
    kd = ((t2_25 - t25) <<< 2) + ((t2_25 - t25) <<< 1);
    dff = 26'(f) - 26'(fu);

    up_a = 27'(fm1) - 27'(fp1);
    up_b = 27'(fm1) + 27'(fp1) - (27'(f) <<< 1);
    fp_a = 30'(fm2) - ((30'(fm1) - 30'(fp1)) <<< 2) - 30'(fp2);
    fp_b = 30'(fm2) - ((30'(fm1) + 30'(fp1)) <<< 2) + (30'(f) <<< 2) + (30'(f) <<< 1)
           + 30'(fp2);
  end

  // Shared multiplier.
  assign mul = opa * opb;

  // Rounded forms of the product and of the accumulated sum.
  always_comb begin
    sum60 = 60'(acc_r) + 60'(prod_r);
    r15p  = asp_pkg::rnd_shift(60'(prod_r), 5'd15);
    r15s  = asp_pkg::rnd_shift(sum60, 5'd15);
    r16p  = asp_pkg::rnd_shift(60'(prod_r), 5'd16);
    r16s  = asp_pkg::rnd_shift(sum60, 5'd16);
    r17s  = asp_pkg::rnd_shift(sum60, 5'd17);
    r10p  = asp_pkg::rnd_shift(60'(prod_r), 5'd10);
    x16   = r16p[W-1:0];
    y10   = r10p[W-1:0];
  end

  // Final value and slope of the update.
  always_comb begin
    ng = W'(g);
    unique case (cfg.scheme)
      asp_pkg::SCHEME_FIVE_POINT: nf = W'(f) - r17s[W-1:0];
      asp_pkg::SCHEME_CIP: begin
        nf = W'(f) + df_r;
        ng = s_pos ? (W'(g) + W'(dg_r) - y10) : (W'(g) + W'(dg_r) + y10);
      end
      default: nf = W'(f) + r16s[W-1:0];
    endcase
  end

  assign out_load = ctl.fin && (!out_valid_r || out_ready);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asp_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (cfg.scheme == asp_pkg::SCHEME_CIP) state_nxt = asp_pkg::BK_C0;
          else if (cfg.scheme == asp_pkg::SCHEME_FIVE_POINT) state_nxt = asp_pkg::BK_FP0;
          else state_nxt = asp_pkg::BK_UP0;
        end
      end
      asp_pkg::BK_UP0: state_nxt = asp_pkg::BK_UP1;
      asp_pkg::BK_UP1: state_nxt = asp_pkg::BK_FIN;
      asp_pkg::BK_FP0: state_nxt = asp_pkg::BK_FP1;
      asp_pkg::BK_FP1: state_nxt = asp_pkg::BK_FIN;
      asp_pkg::BK_C0:  state_nxt = asp_pkg::BK_C1;
      asp_pkg::BK_C1:  state_nxt = asp_pkg::BK_C2;
      asp_pkg::BK_C2:  state_nxt = asp_pkg::BK_C3;
      asp_pkg::BK_C3:  state_nxt = asp_pkg::BK_C4;
      asp_pkg::BK_C4:  state_nxt = asp_pkg::BK_C5;
      asp_pkg::BK_C5:  state_nxt = asp_pkg::BK_C6;
      asp_pkg::BK_C6:  state_nxt = asp_pkg::BK_C7;
      asp_pkg::BK_C7:  state_nxt = asp_pkg::BK_C8;
      asp_pkg::BK_C8:  state_nxt = asp_pkg::BK_C9;
      asp_pkg::BK_C9:  state_nxt = asp_pkg::BK_C10;
      asp_pkg::BK_C10: state_nxt = asp_pkg::BK_C11;
      asp_pkg::BK_C11: state_nxt = asp_pkg::BK_C12;
      asp_pkg::BK_C12: state_nxt = asp_pkg::BK_FIN;
      asp_pkg::BK_FIN: if (out_load) state_nxt = asp_pkg::BK_IDLE;
      default:         state_nxt = asp_pkg::BK_IDLE;
    endcase
  end

  // Operand selection and load enables for each step.
  always_comb begin
    ctl = '0;
    opa = '0;
    opb = '0;
    unique case (state_r)
      asp_pkg::BK_IDLE: ctl.take = 1'b1;
      asp_pkg::BK_UP0: begin
        ctl.ld_prod = 1'b1; opa = 34'(up_a); opb = c25;
      end
      asp_pkg::BK_UP1: begin
        ctl.ld_prod = 1'b1; ctl.ld_acc = 1'b1; opa = 34'(up_b); opb = t25;
      end
      asp_pkg::BK_FP0: begin
        ctl.ld_prod = 1'b1; opa = 34'(fp_a); opb = c25;
      end
      asp_pkg::BK_FP1: begin
        ctl.ld_prod = 1'b1; ctl.ld_acc = 1'b1; opa = 34'(fp_b); opb = t25;
      end
      asp_pkg::BK_C0: begin
        ctl.ld_prod = 1'b1; opa = 34'(t); opb = t25;
      end
      asp_pkg::BK_C1: ctl.ld_t2 = 1'b1;
      asp_pkg::BK_C2: begin
        ctl.ld_prod = 1'b1; opa = 34'(t2_r); opb = t25;
      end
      asp_pkg::BK_C3: ctl.ld_t3 = 1'b1;
      asp_pkg::BK_C4: begin
        ctl.ld_prod = 1'b1; opa = 34'(dff); opb = ka;
      end
      asp_pkg::BK_C5: begin
        ctl.ld_a = 1'b1; ctl.ld_prod = 1'b1; opa = 34'(g); opb = k1;
      end
      asp_pkg::BK_C6: begin
        ctl.ld_acc = 1'b1; ctl.ld_prod = 1'b1; opa = 34'(gu); opb = k2;
      end
      asp_pkg::BK_C7: begin
        ctl.ld_p = 1'b1; ctl.ld_prod = 1'b1; opa = 34'(g); opb = kb;
      end
      asp_pkg::BK_C8: begin
        ctl.ld_acc = 1'b1; ctl.ld_prod = 1'b1; opa = 34'(gu); opb = kc;
      end
      asp_pkg::BK_C9: begin
        ctl.ld_dg = 1'b1; ctl.ld_prod = 1'b1; opa = p_r; opb = h25;
      end
      asp_pkg::BK_C10: begin
        ctl.ld_df = 1'b1; ctl.ld_prod = 1'b1; opa = 34'(dff); opb = kd;
      end
      asp_pkg::BK_C11: ctl.ld_q = 1'b1;
      asp_pkg::BK_C12: begin
        ctl.ld_prod = 1'b1; opa = 34'(q_r); opb = inv25;
      end
      asp_pkg::BK_FIN: ctl.fin = 1'b1;
      default: ctl = '0;
    endcase
  end

  assign job_ready = ctl.take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.take && job_valid) job_r <= job;
    if (ctl.ld_prod) prod_r <= mul;
    if (ctl.ld_acc) acc_r <= prod_r;
    if (ctl.ld_t2) t2_r <= r15p[17:0];
    if (ctl.ld_t3) t3_r <= r15p[17:0];
    if (ctl.ld_a) a_r <= r15p[27:0];
    if (ctl.ld_p) p_r <= r15s[33:0];
    if (ctl.ld_dg) dg_r <= r15s[35:0];
    if (ctl.ld_df) df_r <= s_pos ? (W'(a_r) - x16) : (W'(a_r) + x16);
    if (ctl.ld_q) q_r <= r15p[26:0];
    if (out_load) begin
      out_value_r <= asp_pkg::sat_value(nf);
      out_slope_r <= asp_pkg::sat_slope(ng);
      out_last_r  <= job_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_slope = out_slope_r;
  assign out_last  = out_last_r;

endmodule

[design/advection_stencil_step_core.sv]
// Each update steps through BK_UP0, BK_UP1 (upwind), BK_FP0, BK_FP1 (five-point) or
// BK_C0 to BK_C12 (CIP), set by the single shared multiplier, then waits in BK_FIN until
// the output register is free; a new update is taken only back in BK_IDLE. A last cell
// releases up to three results, which queue between front and back end.
// Reset (rst_n low, synchronous) empties the windows, the queue and the output register
// and loads the register defaults; no clearing pass is needed.
module advection_stencil_step_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [asp_pkg::DATA_BITS-1:0] in_tdata,   // cell_value [23:0], cell_slope [55:24]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [asp_pkg::DATA_BITS-1:0] out_tdata,  // new_value [23:0], new_slope [55:24]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [asp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [asp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  asp_pkg::asp_cfg_t cfg_r, cfg_nxt;
  asp_pkg::asp_job_t fr_job, bk_job;
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  logic [asp_pkg::VALUE_BITS-1:0] out_value;
  logic [asp_pkg::SLOPE_BITS-1:0] out_slope;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        asp_pkg::CFG_SCHEME:    cfg_nxt.scheme     = cfg_wdata[1:0];
        asp_pkg::CFG_COURANT:   cfg_nxt.courant    = $signed(cfg_wdata[15:0]);
        asp_pkg::CFG_WIDTH:     cfg_nxt.cell_width = cfg_wdata[15:0];
        asp_pkg::CFG_INV_WIDTH: cfg_nxt.inv_width  = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scheme     <= asp_pkg::SCHEME_UPWIND;
      cfg_r.courant    <= 16'sd3277;
      cfg_r.cell_width <= 16'd655;
      cfg_r.inv_width  <= 24'd6553600;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  asp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata[asp_pkg::VALUE_BITS-1:0]),
    .in_slope  (in_tdata[asp_pkg::DATA_BITS-1:asp_pkg::VALUE_BITS]),
    .in_last   (in_tlast),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  asp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_job   (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_job    (bk_job)
  );

  asp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value),
    .out_slope (out_slope),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_slope, out_value};

endmodule

[tb/sv/advection_stencil_step_core_tb.sv]
`timescale 1ns / 1ps

module advection_stencil_step_core_tb;
  import asp_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd5;
  localparam logic [1:0] SCHEME_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [SLOPE_BITS-1:0] slope;
    logic                  row_end;
  } cell_update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_BITS-1:0] in_tdata = '0;   // cell_value [23:0], cell_slope [55:24]
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_BITS-1:0] out_tdata;       // new_value [23:0], new_slope [55:24]
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Mirror of the block's registers and row windows.
  logic [1:0] mdl_scheme;
  longint mdl_courant, mdl_width, mdl_inv_width;
  longint val_win[5];
  longint slope_win[3];
  int row_cells;

  cell_update_t pending_updates[$];
  int error_count = 0;
  int cells_sent = 0;
  int updates_checked = 0;
  int rows_sent = 0;
  bit steady = 1'b0;

  advection_stencil_step_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint rnd(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Work out one updated cell from its value and slope neighborhoods.
  function automatic void predict_update(longint fw[5], longint gw[3], bit row_end);
    cell_update_t u;
    longint c, ac, f, g, nf, ng, s, fu, gu, t, t2, t3, a, p, q, df, dg;
    c = mdl_courant;
    ac = c < 0 ? -c : c;
    f = fw[2];
    g = gw[1];
    ng = g;
    if (mdl_scheme == SCHEME_FIVE_POINT) begin
      a = fw[0] - 4 * (fw[1] - fw[3]) - fw[4];
      p = fw[0] - 4 * (fw[1] + fw[3]) + 6 * f + fw[4];
      nf = f - rnd(c * a + ac * p, 17);
    end else if (mdl_scheme == SCHEME_CIP) begin
      s = c > 0 ? 1 : -1;
      fu = s > 0 ? fw[1] : fw[3];
      gu = s > 0 ? gw[0] : gw[2];
      t = ac;
      t2 = rnd(t * t, 15);
      t3 = rnd(t2 * t, 15);
      a = rnd(2 * (f - fu) * t3 + 3 * (fu - f) * t2, 15);
      p = rnd((g + gu) * t3 - (2 * g + gu) * t2 + g * t, 15);
      df = a - s * rnd(p * mdl_width, 16);
      q = rnd(6 * (f - fu) * (t2 - t), 15);
      dg = rnd(3 * (g + gu) * t2 - 2 * (2 * g + gu) * t, 15) - s * rnd(q * mdl_inv_width, 10);
      nf = f + df;
      ng = g + dg;
    end else begin
      nf = f + rnd(c * (fw[1] - fw[3]) + ac * (fw[3] + fw[1] - 2 * f), 16);
    end
    u.value = VALUE_BITS'(clamp(nf, VALUE_BITS));
    u.slope = SLOPE_BITS'(clamp(ng, SLOPE_BITS));
    u.row_end = row_end;
    pending_updates.push_back(u);
  endfunction

  function automatic void clear_row();
    foreach (val_win[k]) val_win[k] = 0;
    foreach (slope_win[k]) slope_win[k] = 0;
    row_cells = 0;
  endfunction

  // Advance the row windows by one accepted cell and queue its updates.
  function automatic void accept_cell(logic [VALUE_BITS-1:0] v, logic [SLOPE_BITS-1:0] g,
                                      bit last);
    longint fw[5];
    longint gw[3];
    for (int k = 4; k > 0; k--) val_win[k] = val_win[k - 1];
    val_win[0] = longint'($signed(v));
    if (row_cells >= 2) begin
      for (int k = 0; k < 5; k++) fw[k] = val_win[4 - k];
      gw[0] = slope_win[2]; gw[1] = slope_win[1]; gw[2] = slope_win[0];
      predict_update(fw, gw, 1'b0);
    end
    slope_win[2] = slope_win[1];
    slope_win[1] = slope_win[0];
    slope_win[0] = longint'($signed(g));
    if (last) begin
      if (row_cells >= 1) begin
        for (int k = 0; k < 4; k++) fw[k] = val_win[3 - k];
        fw[4] = 0;
        gw[0] = slope_win[2]; gw[1] = slope_win[1]; gw[2] = slope_win[0];
        predict_update(fw, gw, 1'b0);
      end
      fw[0] = val_win[2]; fw[1] = val_win[1]; fw[2] = val_win[0];
      fw[3] = 0; fw[4] = 0;
      gw[0] = slope_win[1]; gw[1] = slope_win[0]; gw[2] = 0;
      predict_update(fw, gw, 1'b1);
      clear_row();
    end else if (row_cells < 2) begin
      row_cells++;
    end
  endfunction

  // Send one cell request after a random gap, none while steady; valid stays high for back-to-back cells.
  task automatic send_cell(logic [VALUE_BITS-1:0] v, logic [SLOPE_BITS-1:0] g, bit last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {g, v};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    accept_cell(v, g, last);
    cells_sent++;
    if (last) rows_sent++;
  endtask

  // Stop sending and wait until every queued update has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SCHEME: mdl_scheme = data[1:0];
      CFG_COURANT: mdl_courant = longint'($signed(data[15:0]));
      CFG_WIDTH: mdl_width = longint'(data[15:0]);
      CFG_INV_WIDTH: mdl_inv_width = longint'(data[23:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [1:0] scheme, logic [15:0] c, logic [15:0] w,
                            logic [23:0] iw);
    write_reg(CFG_SCHEME, CFG_DATA_BITS'(scheme));
    write_reg(CFG_COURANT, CFG_DATA_BITS'(c));
    write_reg(CFG_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_INV_WIDTH, iw);
  endtask

  task automatic send_row(int len);
    logic [VALUE_BITS-1:0] v;
    logic [SLOPE_BITS-1:0] g;
    bit wild;
    longint base;
    wild = ($urandom_range(0, 3) == 0);
    base = longint'($signed(VALUE_BITS'($urandom))) >>> $urandom_range(0, 8);
    for (int k = 0; k < len; k++) begin
      if (wild) begin
        v = VALUE_BITS'($urandom);
        g = $urandom;
      end else begin
        // A smooth profile: a ramp with small noise and a modest slope.
        v = VALUE_BITS'(clamp(base + k * 40000 + $urandom_range(0, 8191) - 4096, VALUE_BITS));
        g = SLOPE_BITS'(longint'($signed(SLOPE_BITS'($urandom))) >>> $urandom_range(4, 14));
      end
      send_cell(v, g, k == len - 1);
    end
  endtask

  // Extreme fields under every scheme, short rows, zero Courant and zero spacing.
  task automatic test_directed();
    steady = 1'b0;
    send_cell(24'h7FFFFF, 32'h7FFFFFFF, 1'b1);
    send_cell(24'h800000, 32'h80000000, 1'b0);
    send_cell(24'h7FFFFF, 32'h00000000, 1'b1);
    drain();
    set_config(SCHEME_FIVE_POINT, 16'h7FFF, 16'd1, 24'd1);
    send_cell(24'h7FFFFF, 32'hFFFFFFFF, 1'b0);
    send_cell(24'h800000, 32'h00000001, 1'b0);
    send_cell(24'h7FFFFF, 32'h7FFFFFFF, 1'b0);
    send_cell(24'h800000, 32'h80000000, 1'b1);
    drain();
    set_config(SCHEME_CIP, 16'h8000, 16'hFFFF, 24'hFFFFFF);
    send_cell(24'h123456, 32'h7FFFFFFF, 1'b0);
    send_cell(24'h800000, 32'h80000000, 1'b0);
    send_cell(24'h7FFFFF, 32'h7FFFFFFF, 1'b0);
    send_cell(24'h000000, 32'h80000000, 1'b1);
    drain();
    write_reg(CFG_COURANT, 24'd0);
    send_cell(24'h0F0000, 32'h00100000, 1'b0);
    send_cell(24'hF00000, 32'hFFF00000, 1'b0);
    send_cell(24'h050000, 32'h00000000, 1'b1);
    drain();
    // Zero spacing registers remove the spacing-scaled terms.
    set_config(SCHEME_CIP, 16'd16384, 16'd0, 24'd0);
    send_cell(24'h100000, 32'h00200000, 1'b0);
    send_cell(24'hE00000, 32'hFFE00000, 1'b0);
    send_cell(24'h300000, 32'h00300000, 1'b1);
    drain();
    // The spare scheme code behaves as upwind; an unused index changes nothing.
    write_reg(CFG_SCHEME, CFG_DATA_BITS'(SCHEME_SPARE));
    write_reg(CFG_UNUSED_INDEX, 24'hFFFFFF);
    send_cell(24'h400000, 32'h12345678, 1'b0);
    send_cell(24'hC00000, 32'h87654321, 1'b1);
    drain();
  endtask

  // Random rows under a sequence of register settings.
  task automatic test_random_rows();
    logic [15:0] c;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: c = 16'h7FFF;
        1: c = 16'h8000;
        default: c = 16'($urandom);
      endcase
      set_config(2'($urandom_range(0, 3)), c,
                 phase == 5 ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                 phase == 6 ? 24'hFFFFFF : 24'($urandom_range(1, 24'hFFFFFF)));
      steady = (phase % 3 == 1);
      while (cells_sent < 20 + 25 * (phase + 1)) begin
        send_row($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 12));
      end
      drain();
    end
    steady = 1'b0;
  endtask

  // The sender holds off mid-row until every expected update has arrived.
  task automatic test_pause_mid_row();
    set_config(SCHEME_CIP, 16'd9000, 16'd655, 24'd6553600);
    for (int k = 0; k < 6; k++) begin
      send_cell(VALUE_BITS'($urandom), 32'($urandom) >>> 6, 1'b0);
      if (k == 3) drain();
    end
    send_cell(24'h012345, 32'h00001234, 1'b1);
    drain();
  endtask

  // Result ready: a random stall before each result, none while steady.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each accepted result with the oldest expected update.
  always @(posedge clk) begin
    cell_update_t exp_upd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result %h last %b", out_tdata, out_tlast);
        error_count++;
      end else begin
        exp_upd = pending_updates.pop_front();
        updates_checked++;
        if (out_tdata[VALUE_BITS-1:0] !== exp_upd.value) begin
          $error("new_value expected %h actual %h", exp_upd.value, out_tdata[VALUE_BITS-1:0]);
          error_count++;
        end
        if (out_tdata[DATA_BITS-1:VALUE_BITS] !== exp_upd.slope) begin
          $error("new_slope expected %h actual %h", exp_upd.slope,
                 out_tdata[DATA_BITS-1:VALUE_BITS]);
          error_count++;
        end
        if (out_tlast !== exp_upd.row_end) begin
          $error("row_end expected %b actual %b", exp_upd.row_end, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    mdl_scheme = SCHEME_UPWIND;
    mdl_courant = 3277;
    mdl_width = 655;
    mdl_inv_width = 6553600;
    clear_row();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_rows();
    test_pause_mid_row();
    drain();
    if (pending_updates.size() != 0) begin
      $error("%0d expected results never arrived", pending_updates.size());
      error_count++;
    end
    $display("Sent %0d cells in %0d rows and checked %0d updates", cells_sent, rows_sent,
             updates_checked);
    $display("Covered all schemes, Courant extremes, short rows and a mid-row hold-off");
    if (error_count == 0) begin
      $display("advection_stencil_step_core_tb: done, clean");
    end else begin
      $display("advection_stencil_step_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("advection_stencil_step_core_tb: done, errors");
    $finish;
  end

endmodule
